>>> hdl/ftr_pkg.sv
package ftr_pkg;

    // default transform size, N = 2^LOG2_POINTS
    localparam int LOG2_POINTS_DEF = 6;

    localparam int PHASE_BITS = 12;
    localparam int ROM_DEPTH  = 1025;
    localparam int ROM_ADDR_W = 11;

    // S1 index, S2 phase, S3 rom, S4 sign, S5 mult, S6 sum, S7 round
    localparam int NUM_STAGES = 7;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_BASE  = 1'd1;

    typedef logic signed [15:0] sample_t;
    typedef logic [PHASE_BITS-1:0] phase_t;

    // registered rom output: magnitudes and quadrant signs
    typedef struct packed {
        logic [15:0] sin_mag;
        logic [15:0] cos_mag;
        logic        sin_neg;
        logic        cos_neg;
    } trig_t;

endpackage

>>> hdl/fft_twiddle_rotator.sv
// Twiddle rotator for a four-step FFT of N*N points.
// Throughput: one beat per cycle while the output is not stalled, set by the
// seven-stage pipeline whose rom stage reads sin and cos from the two read
// ports of the sine rom each cycle.
// Reset (rst_n, async, active low): pipeline empty, direction and row_base 0.
// The sine rom is a constant table; there is no fill or clearing pass.
module fft_twiddle_rotator
    import ftr_pkg::*;
#(
    parameter int LOG2_POINTS = LOG2_POINTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input beat
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [5:0]             row,
    input  logic [5:0]             col,
    input  sample_t                sample_re,
    input  sample_t                sample_im,
    // result beat
    output logic                   out_valid,
    input  logic                   out_stall,
    output sample_t                rot_re,
    output sample_t                rot_im
);

    // Stage map:
    //   0  global row and column masked to N
    //   1  k = row*col, scaled to a 12-bit phase, negated for direction
    //   2  sine rom read at the sin and cos addresses
    //   3  quadrant sign applied
    //   4  four 16x16 products
    //   5  real and imaginary sums
    //   6  round to nearest and saturate, output register
    //
    // Each stage holds a valid bit. A stage loads when it is empty or
    // when the stage after it loads, so bubbles collapse under a stall
    // and input keeps flowing until every stage is full.

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] adv;
    logic                  direction_reg;
    logic [5:0]            row_base_reg;

    phase_t  phase;
    sample_t x2, y2;
    trig_t   trig;

    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
                valid_reg[0] <= in_valid;
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (adv[i])
                    valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // configuration registers: the user writes them only while idle; not enforced here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            row_base_reg  <= 6'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DIRECTION: direction_reg <= cfg_data[0];
                REG_ROW_BASE:  row_base_reg  <= cfg_data[5:0];
                default:       ;
            endcase
        end
    end

    ftr_phase #(
        .LOG2_POINTS(LOG2_POINTS)
    ) u_phase (
        .clk       (clk),
        .adv       (adv[1:0]),
        .row       (row),
        .col       (col),
        .sample_re (sample_re),
        .sample_im (sample_im),
        .direction (direction_reg),
        .row_base  (row_base_reg),
        .phase     (phase),
        .x_out     (x2),
        .y_out     (y2)
    );

    ftr_rom u_rom (
        .clk   (clk),
        .adv   (adv[2]),
        .phase (phase),
        .trig  (trig)
    );

    ftr_cmul u_cmul (
        .clk    (clk),
        .adv    (adv[6:2]),
        .x_in   (x2),
        .y_in   (y2),
        .trig   (trig),
        .rot_re (rot_re),
        .rot_im (rot_im)
    );

`ifndef ASSERT_OFF
    // input is held off only when every stage is full and the output stalls
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&valid_reg) && out_stall))
        else $error("input stalled with room in the pipeline");

    // an accepted beat always lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted beat lost at pipeline entry");

    // a drained output with nothing behind it goes empty
    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !valid_reg[NUM_STAGES-2]) |=> !out_valid)
        else $error("result repeated after drain");
`endif

endmodule

>>> hdl/ftr_phase.sv
module ftr_phase
    import ftr_pkg::*;
#(
    parameter int LOG2_POINTS = LOG2_POINTS_DEF
)
(
    input  logic        clk,
    input  logic [1:0]  adv,
    input  logic [5:0]  row,
    input  logic [5:0]  col,
    input  sample_t     sample_re,
    input  sample_t     sample_im,
    input  logic        direction,
    input  logic [5:0]  row_base,
    output phase_t      phase,
    output sample_t     x_out,
    output sample_t     y_out
);

    // global row can reach 126 when N > 64
    localparam int GW   = (LOG2_POINTS > 6) ? 7 : LOG2_POINTS;
    localparam int CW   = (LOG2_POINTS > 6) ? 6 : LOG2_POINTS;
    localparam int KW   = GW + CW;
    localparam int KBITS = 2 * LOG2_POINTS;
    localparam int SH   = (KBITS >= PHASE_BITS) ? KBITS - PHASE_BITS : 0;
    localparam int LSH  = (KBITS <  PHASE_BITS) ? PHASE_BITS - KBITS : 0;
    localparam logic [31:0] HALF = (SH > 0) ? (32'd1 << (SH - 1)) : 32'd0;

    logic [6:0]    row_sum;
    logic [GW-1:0] grow_reg;
    logic [CW-1:0] col_reg;
    sample_t       x1_reg, y1_reg;
    logic [KW-1:0] k;
    phase_t        p_fwd;
    phase_t        phase_next;
    phase_t        phase_reg;
    sample_t       x2_reg, y2_reg;

    assign row_sum = {1'b0, row_base} + {1'b0, row};

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            grow_reg <= row_sum[GW-1:0];
            col_reg  <= col[CW-1:0];
            x1_reg   <= sample_re;
            y1_reg   <= sample_im;
        end
    end

    always_comb
    begin
        k          = KW'(grow_reg) * KW'(col_reg);
        p_fwd      = PHASE_BITS'(((32'(k) + HALF) >> SH) << LSH);
        phase_next = direction ? (PHASE_BITS'(0) - p_fwd) : p_fwd;
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            phase_reg <= phase_next;
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
        end
    end

    assign phase = phase_reg;
    assign x_out = x2_reg;
    assign y_out = y2_reg;

endmodule

>>> hdl/ftr_rom.sv
module ftr_rom
    import ftr_pkg::*;
(
    input  logic   clk,
    input  logic   adv,
    input  phase_t phase,
    output trig_t  trig
);

    typedef logic [15:0] rom_t [ROM_DEPTH];

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Q30 Taylor series of sine, rounded to Q15, clamped to 32767
    function automatic rom_t build_sine_rom();
        rom_t        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] q;
        longint      sum;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            x    = (HALF_PI_Q30 * 64'(i) + 64'd512) >> 10;
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 12; n++)
            begin
                term = (term * x2 + (64'd1 << 29)) >> 30;
                case (n)
                    1:       term = term / 6;
                    2:       term = term / 20;
                    3:       term = term / 42;
                    4:       term = term / 72;
                    5:       term = term / 110;
                    6:       term = term / 156;
                    7:       term = term / 210;
                    8:       term = term / 272;
                    9:       term = term / 342;
                    10:      term = term / 420;
                    11:      term = term / 506;
                    default: term = term / 600;
                endcase
                if ((n & 1) != 0)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            q = (64'(sum) + (64'd1 << 14)) >> 15;
            if (q > 64'd32767)
                q = 64'd32767;
            rom[i] = q[15:0];
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_sine_rom();

    logic [1:0]            quad;
    logic [ROM_ADDR_W-1:0] r_ext;
    logic [ROM_ADDR_W-1:0] mirror;
    logic [ROM_ADDR_W-1:0] sin_addr;
    logic [ROM_ADDR_W-1:0] cos_addr;
    trig_t                 trig_reg;

    // cos(p) = sin(p + quarter turn): next quadrant, opposite mirroring
    always_comb
    begin
        quad     = phase[PHASE_BITS-1 -: 2];
        r_ext    = {1'b0, phase[PHASE_BITS-3:0]};
        mirror   = ROM_ADDR_W'(ROM_DEPTH - 1) - r_ext;
        sin_addr = quad[0] ? mirror : r_ext;
        cos_addr = quad[0] ? r_ext : mirror;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            trig_reg.sin_mag <= SINE_ROM[sin_addr];
            trig_reg.cos_mag <= SINE_ROM[cos_addr];
            trig_reg.sin_neg <= quad[1];
            trig_reg.cos_neg <= quad[1] ^ quad[0];
        end
    end

    assign trig = trig_reg;

endmodule

>>> hdl/ftr_cmul.sv
module ftr_cmul
    import ftr_pkg::*;
(
    input  logic       clk,
    input  logic [4:0] adv,
    input  sample_t    x_in,
    input  sample_t    y_in,
    input  trig_t      trig,
    output sample_t    rot_re,
    output sample_t    rot_im
);

    sample_t              x3_reg, y3_reg;
    sample_t              c4_reg, s4_reg, x4_reg, y4_reg;
    sample_t              c_next, s_next;
    logic signed [31:0]   cx_reg, sy_reg, sx_reg, cy_reg;
    logic signed [32:0]   acc_re_reg, acc_im_reg;
    logic signed [33:0]   rnd_re, rnd_im;
    sample_t              re_next, im_next;
    sample_t              re_reg, im_reg;

    function automatic sample_t round_sat(logic signed [33:0] biased);
        logic signed [18:0] q;
        q = 19'(biased >>> 15);
        if (q > 19'sd32767)
            return 16'sh7fff;
        else if (q < -19'sd32768)
            return 16'sh8000;
        else
            return q[15:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            x3_reg <= x_in;
            y3_reg <= y_in;
        end
    end

    // magnitudes never exceed 32767, so the negation fits
    always_comb
    begin
        c_next = trig.cos_neg ? -$signed(trig.cos_mag) : $signed(trig.cos_mag);
        s_next = trig.sin_neg ? -$signed(trig.sin_mag) : $signed(trig.sin_mag);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            c4_reg <= c_next;
            s4_reg <= s_next;
            x4_reg <= x3_reg;
            y4_reg <= y3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            cx_reg <= 32'(c4_reg) * 32'(x4_reg);
            sy_reg <= 32'(s4_reg) * 32'(y4_reg);
            sx_reg <= 32'(s4_reg) * 32'(x4_reg);
            cy_reg <= 32'(c4_reg) * 32'(y4_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            acc_re_reg <= 33'(cx_reg) - 33'(sy_reg);
            acc_im_reg <= 33'(sx_reg) + 33'(cy_reg);
        end
    end

    // round half up, then clamp
    always_comb
    begin
        rnd_re  = 34'(acc_re_reg) + 34'sd16384;
        rnd_im  = 34'(acc_im_reg) + 34'sd16384;
        re_next = round_sat(rnd_re);
        im_next = round_sat(rnd_im);
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            re_reg <= re_next;
            im_reg <= im_next;
        end
    end

    assign rot_re = re_reg;
    assign rot_im = im_reg;

endmodule
